// ===== src/safl_pkg.sv =====
// shared types and constants for the signal aspect fade led driver
// no dependencies
package safl_pkg;

  localparam int NUM_ASPECTS = 8;
  localparam int NUM_PINS    = 4;
  localparam int BLINK_BIT   = 10;

  localparam logic [7:0] FADE_INTERVAL_RESET = 8'd20;
  localparam logic [3:0] SWITCH_STEP         = 4'd7;
  localparam logic [3:0] LAST_STEP           = 4'd15;
  localparam logic [3:0] PWM_TOP             = 4'd8;

  typedef enum logic [1:0] {
    FUNC_SET_CHANNEL = 2'd0,
    FUNC_TICK        = 2'd1,
    FUNC_REQUEST     = 2'd2,
    FUNC_UNUSED      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CODE_OFF   = 2'd0,
    CODE_LOW   = 2'd1,
    CODE_HIGH  = 2'd2,
    CODE_BLINK = 2'd3
  } pin_code_t;

  typedef enum logic [1:0] {
    REG_MAP_LOW       = 2'd0,
    REG_MAP_HIGH      = 2'd1,
    REG_DIM_TABLE     = 2'd2,
    REG_FADE_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] map_low;
    logic [63:0] map_high;
    logic [59:0] dim_table;
    logic [7:0]  fade_interval;
  } cfg_t;

  // aspect and fade step as they stand after the current transfer
  typedef struct packed {
    logic [2:0] aspect;
    logic [3:0] fade_step;
  } fade_view_t;

endpackage

// ===== src/safl_ctrl.sv =====
// channel bits, aspect selection and fade sequencing
// depends on safl_pkg
module safl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  safl_pkg::func_t      func,
  input  logic [3:0]           ln_channel,
  input  logic                 ln_level,
  input  logic [3:0]           aspect_request,
  input  logic [31:0]          now_ms,
  input  logic [7:0]           fade_interval,
  output safl_pkg::fade_view_t view_next,
  output logic [7:0]           bits_next,
  output logic                 ok
);

  logic [7:0]  channel_bits;
  logic [2:0]  current_aspect;
  logic [2:0]  pending_aspect;
  logic [3:0]  fade_step;
  logic        fade_active;
  logic [31:0] fade_stamp;

  logic [2:0]  aspect_next;
  logic [2:0]  pending_next;
  logic [3:0]  step_next;
  logic        active_next;
  logic [31:0] stamp_next;

  logic [7:0]  bits_set;
  logic        req_hit;
  logic [2:0]  req_val;
  logic [31:0] elapsed;
  logic [3:0]  step_inc;

  always_comb begin
    bits_set = channel_bits;
    bits_set[ln_channel[2:0]] = ln_level;
    elapsed  = now_ms - fade_stamp;
    step_inc = fade_step + 4'd1;

    bits_next    = channel_bits;
    aspect_next  = current_aspect;
    pending_next = pending_aspect;
    step_next    = fade_step;
    active_next  = fade_active;
    stamp_next   = fade_stamp;
    ok           = 1'b1;
    req_hit      = 1'b0;
    req_val      = 3'd0;

    case (func)
      safl_pkg::FUNC_SET_CHANNEL: begin
        if (!ln_channel[3]) begin
          bits_next = bits_set;
          if (bits_set inside {8'd0, 8'd4}) begin
            req_hit = 1'b1;
            req_val = 3'd0;
          end else if (bits_set inside {8'd1, 8'd5}) begin
            req_hit = 1'b1;
            req_val = 3'd3;
          end else if (bits_set == 8'd2) begin
            req_hit = 1'b1;
            req_val = 3'd4;
          end
        end
      end
      safl_pkg::FUNC_REQUEST: begin
        ok      = aspect_request < 4'(safl_pkg::NUM_ASPECTS);
        req_hit = ok;
        req_val = aspect_request[2:0];
      end
      safl_pkg::FUNC_TICK: begin
        if (fade_active && elapsed > {24'd0, fade_interval}) begin
          step_next  = step_inc;
          stamp_next = now_ms;
          if (step_inc == safl_pkg::SWITCH_STEP) begin
            aspect_next = pending_aspect;
          end else if (step_inc == safl_pkg::LAST_STEP) begin
            step_next   = 4'd0;
            active_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    // a new aspect restarts the fade
    if (req_hit && req_val != current_aspect) begin
      active_next  = 1'b1;
      stamp_next   = now_ms;
      step_next    = 4'd0;
      pending_next = req_val;
    end

    view_next.aspect    = aspect_next;
    view_next.fade_step = step_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_bits   <= '0;
      current_aspect <= '0;
      pending_aspect <= '0;
      fade_step      <= '0;
      fade_active    <= 1'b0;
      fade_stamp     <= '0;
    end else if (take) begin
      channel_bits   <= bits_next;
      current_aspect <= aspect_next;
      pending_aspect <= pending_next;
      fade_step      <= step_next;
      fade_active    <= active_next;
      fade_stamp     <= stamp_next;
    end
  end

endmodule

// ===== src/safl_pins.sv =====
// multiplex phase, pwm dimming and per-pin drive from the aspect table
// depends on safl_pkg
module safl_pins (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic                                is_tick,
  input  logic                                blink,
  input  safl_pkg::fade_view_t                view_next,
  input  safl_pkg::cfg_t                      cfg,
  output logic [safl_pkg::NUM_PINS-1:0]       en_next,
  output logic [safl_pkg::NUM_PINS-1:0]       lvl_next
);

  logic                          phase;
  logic [3:0]                    pwm_count;
  logic [safl_pkg::NUM_PINS-1:0] pin_en_reg;
  logic [safl_pkg::NUM_PINS-1:0] pin_lvl_reg;

  logic                          phase_next;
  logic [3:0]                    pwm_next;
  logic [3:0]                    level;
  logic [63:0]                   map;
  logic [4:0]                    slot;
  safl_pkg::pin_code_t           code;

  always_comb begin
    phase_next = phase;
    pwm_next   = pwm_count;
    en_next    = pin_en_reg;
    lvl_next   = pin_lvl_reg;
    slot       = '0;
    code       = safl_pkg::CODE_OFF;
    map        = view_next.aspect[2] ? cfg.map_high : cfg.map_low;
    level      = (view_next.fade_step == safl_pkg::LAST_STEP) ? 4'd0 :
                 cfg.dim_table[{view_next.fade_step, 2'b00} +: 4];

    if (is_tick) begin
      phase_next = ~phase;
      if (!phase) begin
        pwm_next = (pwm_count >= safl_pkg::PWM_TOP) ? 4'd0 : pwm_count + 4'd1;
      end
      if (pwm_next > level) begin
        en_next = '0;
      end else begin
        for (int i = 0; i < safl_pkg::NUM_PINS; i++) begin
          slot = {view_next.aspect[1:0], phase, 2'(i)};
          code = safl_pkg::pin_code_t'(map[{slot, 1'b0} +: 2]);
          case (code)
            safl_pkg::CODE_OFF: begin
              en_next[i] = 1'b0;
            end
            safl_pkg::CODE_LOW: begin
              en_next[i]  = 1'b1;
              lvl_next[i] = 1'b0;
            end
            safl_pkg::CODE_HIGH: begin
              en_next[i]  = 1'b1;
              lvl_next[i] = 1'b1;
            end
            default: begin
              en_next[i]  = ~blink;
              lvl_next[i] = 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= 1'b0;
      pwm_count   <= '0;
      pin_en_reg  <= '0;
      pin_lvl_reg <= '0;
    end else if (take) begin
      phase       <= phase_next;
      pwm_count   <= pwm_next;
      pin_en_reg  <= en_next;
      pin_lvl_reg <= lvl_next;
    end
  end

endmodule

// ===== src/signal_aspect_fade_led_driver.sv =====
// top level of the signal aspect fade led driver: config registers, result register
// depends on safl_pkg, safl_ctrl, safl_pins
//
// One result per input item, one item per clock. An item is worked out in a single
// pass of shallow logic (one 32-bit elapsed-time subtract and compare, table selects)
// and lands in a result register together with the state update; in_ready stays high
// while the result register is empty or being taken, so a transfer can happen every
// cycle. out_valid rises in the cycle after an input transfer. Configuration is taken
// at once through cfg_we; write it only while the block is idle.
module signal_aspect_fade_led_driver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [3:0]  ln_channel,
  input  logic        ln_level,
  input  logic [3:0]  aspect_request,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  pin_enable,
  output logic [3:0]  pin_high,
  output logic [2:0]  shown_aspect,
  output logic [7:0]  ln_bits,
  output logic        accepted,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  safl_pkg::cfg_t       cfg;
  safl_pkg::fade_view_t view_next;
  logic                 take;
  logic [7:0]           bits_next;
  logic                 ok;
  logic [3:0]           en_next;
  logic [3:0]           lvl_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_low       <= '0;
      cfg.map_high      <= '0;
      cfg.dim_table     <= '0;
      cfg.fade_interval <= safl_pkg::FADE_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (safl_pkg::cfg_reg_t'(cfg_index))
        safl_pkg::REG_MAP_LOW:   cfg.map_low   <= cfg_data;
        safl_pkg::REG_MAP_HIGH:  cfg.map_high  <= cfg_data;
        safl_pkg::REG_DIM_TABLE: cfg.dim_table <= cfg_data[59:0];
        default:                 cfg.fade_interval <= cfg_data[7:0];
      endcase
    end
  end

  safl_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .func           (safl_pkg::func_t'(func)),
    .ln_channel     (ln_channel),
    .ln_level       (ln_level),
    .aspect_request (aspect_request),
    .now_ms         (now_ms),
    .fade_interval  (cfg.fade_interval),
    .view_next      (view_next),
    .bits_next      (bits_next),
    .ok             (ok)
  );

  safl_pins u_pins (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .is_tick   (safl_pkg::func_t'(func) == safl_pkg::FUNC_TICK),
    .blink     (now_ms[safl_pkg::BLINK_BIT]),
    .view_next (view_next),
    .cfg       (cfg),
    .en_next   (en_next),
    .lvl_next  (lvl_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pin_enable   <= en_next;
      pin_high     <= lvl_next;
      shown_aspect <= view_next.aspect;
      ln_bits      <= bits_next;
      accepted     <= ok;
    end
  end

endmodule

// ===== src/safl_checker.sv =====
// port-level checks for the signal aspect fade led driver, bound to the top level
// depends on signal_aspect_fade_led_driver ports only
module safl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] pin_enable,
  input logic [7:0] ln_bits,
  input logic       accepted
);

  // a stalled result is held
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every input transfer yields a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without result");

  // results only change through a new transfer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !(in_valid && in_ready) |=>
      $stable(pin_enable) && $stable(ln_bits) && $stable(accepted))
    else $error("result changed without transfer");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind signal_aspect_fade_led_driver safl_checker u_safl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pin_enable (pin_enable),
  .ln_bits    (ln_bits),
  .accepted   (accepted)
);

// ===== test/signal_aspect_fade_led_driver_tb.sv =====
`timescale 1ns / 1ps
// testbench for signal_aspect_fade_led_driver: directed items, then random fade episodes
// checked against an in-bench model of the channel bits, fade sequencer, pwm and pin table
// depends on safl_pkg and the signal_aspect_fade_led_driver rtl
module signal_aspect_fade_led_driver_tb;

  typedef struct packed {
    safl_pkg::func_t func;
    logic [3:0]      ln_channel;
    logic            ln_level;
    logic [3:0]      aspect_request;
    logic [31:0]     now_ms;
  } sig_item_t;

  typedef struct packed {
    logic [3:0] pin_enable;
    logic [3:0] pin_high;
    logic [2:0] shown_aspect;
    logic [7:0] ln_bits;
    logic       accepted;
  } pin_frame_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [3:0]  ln_channel = '0;
  logic        ln_level = 1'b0;
  logic [3:0]  aspect_request = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  pin_enable;
  logic [3:0]  pin_high;
  logic [2:0]  shown_aspect;
  logic [7:0]  ln_bits;
  logic        accepted;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  signal_aspect_fade_led_driver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .ln_channel(ln_channel), .ln_level(ln_level),
    .aspect_request(aspect_request), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .pin_enable(pin_enable), .pin_high(pin_high), .shown_aspect(shown_aspect),
    .ln_bits(ln_bits), .accepted(accepted),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // model copy of the configuration
  logic [63:0] lamp_map_low = '0;
  logic [63:0] lamp_map_high = '0;
  logic [59:0] lamp_dim = '0;
  logic [7:0]  lamp_interval = safl_pkg::FADE_INTERVAL_RESET;

  // model copy of the signal state
  logic [7:0]  sig_bits = '0;
  logic [2:0]  sig_shown = '0;
  logic [2:0]  sig_target = '0;
  logic [3:0]  sig_step = '0;
  logic        sig_fading = 1'b0;
  logic [31:0] sig_stamp = '0;
  logic        sig_phase = 1'b0;
  logic [3:0]  sig_pwm = '0;
  logic [3:0]  sig_en = '0;
  logic [3:0]  sig_lvl = '0;

  sig_item_t  item_backlog[$];
  pin_frame_t due_outputs[$];
  sig_item_t  offered;
  logic [31:0] ms_now;
  int mismatches = 0;
  int send_wait = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int hold_left = 0;
  int taken = 0;
  bit long_hold_done = 1'b0;

  function automatic logic take_aspect(logic [3:0] v, logic [31:0] now);
    if (v >= safl_pkg::NUM_ASPECTS) return 1'b0;
    if (v[2:0] != sig_shown) begin
      sig_fading = 1'b1;
      sig_stamp  = now;
      sig_step   = 4'd0;
      sig_target = v[2:0];
    end
    return 1'b1;
  endfunction

  function automatic void run_tick(logic [31:0] now);
    logic [31:0] elapsed;
    logic        ph;
    logic [3:0]  level;
    logic [63:0] map;
    int          pos;
    elapsed = now - sig_stamp;
    if (sig_fading && elapsed > {24'd0, lamp_interval}) begin
      sig_step  = sig_step + 4'd1;
      sig_stamp = now;
      if (sig_step == safl_pkg::SWITCH_STEP) begin
        sig_shown = sig_target;
      end else if (sig_step == safl_pkg::LAST_STEP) begin
        sig_step   = 4'd0;
        sig_fading = 1'b0;
      end
    end
    ph = sig_phase;
    sig_phase = ~ph;
    level = (sig_step == safl_pkg::LAST_STEP) ? 4'd0 : lamp_dim[4 * sig_step +: 4];
    if (!ph) begin
      sig_pwm = sig_pwm + 4'd1;
      if (sig_pwm > safl_pkg::PWM_TOP) sig_pwm = 4'd0;
    end
    if (sig_pwm > level) begin
      sig_en = 4'd0;
    end else begin
      map = sig_shown[2] ? lamp_map_high : lamp_map_low;
      for (int i = 0; i < safl_pkg::NUM_PINS; i++) begin
        pos = 2 * (8 * sig_shown[1:0] + i + 4 * ph);
        case (safl_pkg::pin_code_t'(map[pos +: 2]))
          safl_pkg::CODE_OFF: sig_en[i] = 1'b0;
          safl_pkg::CODE_LOW: begin
            sig_en[i]  = 1'b1;
            sig_lvl[i] = 1'b0;
          end
          safl_pkg::CODE_HIGH: begin
            sig_en[i]  = 1'b1;
            sig_lvl[i] = 1'b1;
          end
          default: begin
            sig_en[i]  = ~now[safl_pkg::BLINK_BIT];
            sig_lvl[i] = 1'b0;
          end
        endcase
      end
    end
  endfunction

  function automatic pin_frame_t predict_signal(sig_item_t it);
    logic ok;
    ok = 1'b1;
    case (it.func)
      safl_pkg::FUNC_SET_CHANNEL: begin
        if (it.ln_channel < 8) begin
          sig_bits[it.ln_channel[2:0]] = it.ln_level;
          case (sig_bits)
            8'd0, 8'd4: void'(take_aspect(4'd0, it.now_ms));
            8'd1, 8'd5: void'(take_aspect(4'd3, it.now_ms));
            8'd2:       void'(take_aspect(4'd4, it.now_ms));
            default: ;
          endcase
        end
      end
      safl_pkg::FUNC_TICK:    run_tick(it.now_ms);
      safl_pkg::FUNC_REQUEST: ok = take_aspect(it.aspect_request, it.now_ms);
      default: ;
    endcase
    return {sig_en, sig_lvl, sig_shown, sig_bits, ok};
  endfunction

  // mostly short gaps, a few long ones, and runs with none at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sig_item_t random_item(int tick_pct, int step_max);
    sig_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) ms_now = $urandom;
    else if (r < 10) ms_now = ms_now + $urandom_range(step_max, 4 * step_max + 300);
    else ms_now = ms_now + $urandom_range(0, step_max);
    it.now_ms = ms_now;
    it.ln_channel = 4'($urandom);
    it.ln_level = 1'($urandom);
    it.aspect_request = 4'($urandom);
    if ($urandom_range(0, 99) < tick_pct) begin
      it.func = safl_pkg::FUNC_TICK;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it.func = safl_pkg::FUNC_SET_CHANNEL;
        r = $urandom_range(0, 99);
        if (r < 60) begin
          it.ln_channel = 4'($urandom_range(0, 2));
        end else if (r < 85) begin
          it.ln_channel = 4'($urandom_range(3, 7));
          it.ln_level = ($urandom_range(0, 4) == 0);
        end else begin
          it.ln_channel = 4'($urandom_range(8, 15));
        end
      end else if (r < 92) begin
        it.func = safl_pkg::FUNC_REQUEST;
        if ($urandom_range(0, 99) < 85)
          it.aspect_request = 4'($urandom_range(0, safl_pkg::NUM_ASPECTS - 1));
      end else begin
        it.func = safl_pkg::FUNC_UNUSED;
      end
    end
    return it;
  endfunction

  function automatic logic [63:0] random_dim_table();
    logic [63:0] t;
    t = {$urandom, $urandom};
    for (int k = 0; k < 15; k++)
      t[4 * k +: 4] = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
    return t;
  endfunction

  task automatic write_cfg(safl_pkg::cfg_reg_t idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      safl_pkg::REG_MAP_LOW:   lamp_map_low = data;
      safl_pkg::REG_MAP_HIGH:  lamp_map_high = data;
      safl_pkg::REG_DIM_TABLE: lamp_dim = data[59:0];
      default:                 lamp_interval = data[7:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [63:0] lo, logic [63:0] hi, logic [63:0] dim,
                            logic [7:0] ivl);
    write_cfg(safl_pkg::REG_MAP_LOW, lo);
    write_cfg(safl_pkg::REG_MAP_HIGH, hi);
    write_cfg(safl_pkg::REG_DIM_TABLE, dim);
    write_cfg(safl_pkg::REG_FADE_INTERVAL, {$urandom, 24'($urandom), ivl});
  endtask

  task automatic add_item(safl_pkg::func_t f, logic [3:0] ch, logic lv, logic [3:0] req,
                          logic [31:0] now);
    sig_item_t it;
    it.func = f;
    it.ln_channel = ch;
    it.ln_level = lv;
    it.aspect_request = req;
    it.now_ms = now;
    item_backlog.push_back(it);
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (item_backlog.size() != 0 || in_valid || due_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_outputs.push_back(predict_signal(offered));
        send_wait = pick_gap(send_calm);
      end
      if (!in_valid || in_ready) begin
        if (send_wait == 0 && item_backlog.size() != 0) begin
          offered = item_backlog.pop_front();
          in_valid <= 1'b1;
          func <= offered.func;
          ln_channel <= offered.ln_channel;
          ln_level <= offered.ln_level;
          aspect_request <= offered.aspect_request;
          now_ms <= offered.now_ms;
        end else begin
          in_valid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end
      end
    end
  end

  // receiver, with one long hold-off once traffic is under way
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken++;
      if (hold_left > 1) begin
        hold_left--;
      end else if (hold_left == 1) begin
        hold_left = 0;
        out_ready <= 1'b1;
      end else begin
        n = pick_gap(recv_calm);
        if (taken >= 300 && !long_hold_done) begin
          n = 150;
          long_hold_done = 1'b1;
        end
        out_ready <= (n == 0);
        hold_left = n;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pin_frame_t seen;
    pin_frame_t want;
    if (!rst && out_valid && out_ready) begin
      seen = {pin_enable, pin_high, shown_aspect, ln_bits, accepted};
      if (due_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: en=%h hi=%h aspect=%0d bits=%h acc=%b",
                   seen.pin_enable, seen.pin_high, seen.shown_aspect, seen.ln_bits,
                   seen.accepted);
      end else begin
        want = due_outputs.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected en=%h hi=%h aspect=%0d bits=%h acc=%b",
                     want.pin_enable, want.pin_high, want.shown_aspect, want.ln_bits,
                     want.accepted);
            $display("          got      en=%h hi=%h aspect=%0d bits=%h acc=%b",
                     seen.pin_enable, seen.pin_high, seen.shown_aspect, seen.ln_bits,
                     seen.accepted);
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] t0;
    int n;
    int run;
    int step_max;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: all pin codes, levels past the pwm top, zero interval, time wrap
    set_config(64'hE4E4_E4E4_E4E4_E4E4, 64'h1B6C_E4B1_9C27_D8E4,
               {4'($urandom), 60'hF98_7654_3210_8888}, 8'd0);
    t0 = 32'hFFFF_FFF0;
    add_item(safl_pkg::FUNC_UNUSED, 4'd15, 1'b1, 4'd15, 32'hFFFF_FFFF);
    add_item(safl_pkg::FUNC_REQUEST, 4'd0, 1'b0, 4'd15, t0);
    add_item(safl_pkg::FUNC_REQUEST, 4'd0, 1'b0, 4'd8, t0);
    add_item(safl_pkg::FUNC_REQUEST, 4'd0, 1'b0, 4'd0, t0);
    add_item(safl_pkg::FUNC_SET_CHANNEL, 4'd8, 1'b1, 4'd0, t0);
    add_item(safl_pkg::FUNC_SET_CHANNEL, 4'd15, 1'b1, 4'd0, t0);
    add_item(safl_pkg::FUNC_TICK, 4'd0, 1'b0, 4'd0, t0);
    add_item(safl_pkg::FUNC_SET_CHANNEL, 4'd1, 1'b1, 4'd0, t0);
    for (int k = 1; k <= 3; k++) add_item(safl_pkg::FUNC_TICK, 4'd0, 1'b0, 4'd0, t0 + k);
    add_item(safl_pkg::FUNC_REQUEST, 4'd0, 1'b0, 4'd7, t0 + 3);
    for (int k = 4; k <= 20; k++) add_item(safl_pkg::FUNC_TICK, 4'd0, 1'b0, 4'd0, t0 + k);
    add_item(safl_pkg::FUNC_REQUEST, 4'd0, 1'b0, 4'd7, t0 + 21);
    drain();
    ms_now = t0 + 21;

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: set_config('1, '1, '1, 8'd255);
        2: set_config('0, '0, {4'($urandom), 60'd0}, 8'd0);
        3: set_config({$urandom, $urandom}, {$urandom, $urandom}, random_dim_table(), 8'd20);
        default: set_config({$urandom, $urandom}, {$urandom, $urandom}, random_dim_table(),
                            8'($urandom));
      endcase
      step_max = int'(lamp_interval) + 12;
      n = 0;
      // each episode: an aspect change or other command, then mostly ticks
      while (n < 70) begin
        item_backlog.push_back(random_item(20, step_max));
        n++;
        run = $urandom_range(8, 40);
        repeat (run) begin
          item_backlog.push_back(random_item(90, step_max));
          n++;
        end
      end
      drain();
    end

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
